// ----- hdl/swc_pkg.sv -----
// Package for the square-wave sweep channel: beat payload types, channel
// state record, command and register codes, and the small helper functions.
// Standalone; used by swc_core and square_wave_sweep_channel.
`default_nettype none

package swc_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] reg_select;
    logic [7:0] write_data;
  } swc_in_t;

  typedef struct packed {
    logic [3:0] sample_level;
    logic       channel_on;
  } swc_out_t;

  typedef struct packed {
    logic [13:0] period_timer;
    logic [2:0]  duty_step;
    logic [4:0]  duty_pos;
    logic [7:0]  sweep_byte;
    logic [7:0]  duty_length_byte;
    logic [7:0]  envelope_byte;
    logic [7:0]  freq_low_byte;
    logic [7:0]  freq_ctrl_byte;
    logic        dac_on;
    logic [3:0]  env_timer;
    logic [3:0]  volume_level;
    logic [6:0]  length_count;
    logic        active;
    logic [3:0]  out_level;
    logic [3:0]  sweep_timer;
    logic        sweep_active;
    logic [10:0] shadow_freq;
  } swc_state_t;

  // command codes
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_LENGTH   = 3'd1;
  localparam logic [2:0] MODE_SWEEP    = 3'd2;
  localparam logic [2:0] MODE_ENVELOPE = 3'd3;
  localparam logic [2:0] MODE_WRITE    = 3'd4;
  localparam logic [2:0] MODE_DISABLE  = 3'd5;

  // register select codes
  localparam logic [2:0] REG_SWEEP     = 3'd0;
  localparam logic [2:0] REG_DUTY_LEN  = 3'd1;
  localparam logic [2:0] REG_ENVELOPE  = 3'd2;
  localparam logic [2:0] REG_FREQ_LOW  = 3'd3;
  localparam logic [2:0] REG_FREQ_CTRL = 3'd4;

  localparam logic [6:0] LENGTH_FULL   = 7'd64;
  localparam logic [3:0] TIMER_DEFAULT = 4'd8;
  localparam logic [11:0] FREQ_SPAN    = 12'd2048;

  // duty waveforms, four patterns of eight steps, bit i is step i
  localparam logic [31:0] WAVE_TAB = 32'h7EE18180;

  function automatic logic [13:0] timer_reload(input logic [10:0] freq);
    logic [11:0] span;
    span = FREQ_SPAN - {1'b0, freq};
    return {span, 2'b00};
  endfunction

  // bit 11 set means the result overflowed past 2047
  function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
                                             input logic        decrease,
                                             input logic [2:0]  shift);
    logic [10:0] delta;
    delta = shadow >> shift;
    return decrease ? ({1'b0, shadow} - {1'b0, delta})
                    : ({1'b0, shadow} + {1'b0, delta});
  endfunction

  function automatic logic [3:0] level_calc(input logic       active,
                                            input logic       dac_on,
                                            input logic [3:0] volume,
                                            input logic [4:0] pos);
    return (active && dac_on && WAVE_TAB[pos]) ? volume : 4'd0;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/swc_core.sv -----
// Channel state registers and the combinational next-state update for one command beat.
// Depends on swc_pkg.
`default_nettype none

module swc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire swc_pkg::swc_in_t  item,
  output swc_pkg::swc_out_t      result
);
  import swc_pkg::*;

  swc_state_t st_r, st_nxt;

  logic [10:0] freq_cur;
  logic [2:0]  step_inc;
  logic [4:0]  tick_pos;
  logic [2:0]  sw_period;
  logic [2:0]  sw_shift;
  logic [3:0]  sw_reload;
  logic [11:0] calc_one;
  logic [11:0] calc_two;
  logic        sweep_ovf;
  logic [10:0] trig_freq;
  logic [11:0] trig_calc;
  logic        trig_active;
  logic [2:0]  env_period;
  logic [4:0]  wr_pos;

  assign freq_cur  = {st_r.freq_ctrl_byte[2:0], st_r.freq_low_byte};
  assign step_inc  = st_r.duty_step + 3'd1;
  assign tick_pos  = {st_r.duty_length_byte[7:6], step_inc};
  assign sw_period = st_r.sweep_byte[6:4];
  assign sw_shift  = st_r.sweep_byte[2:0];
  assign sw_reload = (sw_period != 3'd0) ? {1'b0, sw_period} : TIMER_DEFAULT;
  assign env_period = st_r.envelope_byte[2:0];
  assign wr_pos    = {item.write_data[7:6], st_r.duty_step};

  // sweep step: a second calc on the updated shadow only matters for overflow
  assign calc_one  = sweep_calc(st_r.shadow_freq, st_r.sweep_byte[3], sw_shift);
  assign calc_two  = sweep_calc(calc_one[10:0], st_r.sweep_byte[3], sw_shift);
  assign sweep_ovf = calc_one[11] ||
                     (!calc_one[11] && (sw_shift != 3'd0) && calc_two[11]);

  assign trig_freq   = {item.write_data[2:0], st_r.freq_low_byte};
  assign trig_calc   = sweep_calc(trig_freq, st_r.sweep_byte[3], sw_shift);
  assign trig_active = !((sw_shift != 3'd0) && trig_calc[11]);

  always_comb begin
    st_nxt = st_r;
    if (step_en) begin
      case (item.mode)
        MODE_TICK: begin
          if (st_r.period_timer <= 14'd1) begin
            st_nxt.duty_step    = step_inc;
            st_nxt.period_timer = timer_reload(freq_cur);
            st_nxt.duty_pos     = tick_pos;
            st_nxt.out_level    = level_calc(st_r.active, st_r.dac_on,
                                             st_r.volume_level, tick_pos);
          end else begin
            st_nxt.period_timer = st_r.period_timer - 14'd1;
          end
        end
        MODE_LENGTH: begin
          if ((st_r.length_count != 7'd0) && st_r.freq_ctrl_byte[6]) begin
            st_nxt.length_count = st_r.length_count - 7'd1;
            if (st_r.length_count == 7'd1) begin
              st_nxt.active    = 1'b0;
              st_nxt.out_level = 4'd0;
            end
          end
        end
        MODE_SWEEP: begin
          if (st_r.sweep_timer > 4'd1) begin
            st_nxt.sweep_timer = st_r.sweep_timer - 4'd1;
          end else begin
            st_nxt.sweep_timer = sw_reload;
            if (st_r.sweep_active && (sw_period != 3'd0)) begin
              if (!calc_one[11] && (sw_shift != 3'd0)) begin
                st_nxt.shadow_freq    = calc_one[10:0];
                st_nxt.freq_low_byte  = calc_one[7:0];
                st_nxt.freq_ctrl_byte = {st_r.freq_ctrl_byte[7:3], calc_one[10:8]};
              end
              if (sweep_ovf) begin
                st_nxt.active    = 1'b0;
                st_nxt.out_level = 4'd0;
              end
            end
          end
        end
        MODE_ENVELOPE: begin
          if (st_r.env_timer > 4'd1) begin
            st_nxt.env_timer = st_r.env_timer - 4'd1;
          end else begin
            st_nxt.env_timer = (env_period != 3'd0) ? {1'b0, env_period}
                                                    : TIMER_DEFAULT;
            if (env_period != 3'd0) begin
              if (st_r.envelope_byte[3]) begin
                if (st_r.volume_level != 4'd15)
                  st_nxt.volume_level = st_r.volume_level + 4'd1;
              end else begin
                if (st_r.volume_level != 4'd0)
                  st_nxt.volume_level = st_r.volume_level - 4'd1;
              end
            end
          end
        end
        MODE_WRITE: begin
          case (item.reg_select)
            REG_SWEEP: begin
              st_nxt.sweep_byte = item.write_data;
            end
            REG_DUTY_LEN: begin
              st_nxt.duty_length_byte = item.write_data;
              st_nxt.duty_pos         = wr_pos;
              st_nxt.out_level        = level_calc(st_r.active, st_r.dac_on,
                                                   st_r.volume_level, wr_pos);
            end
            REG_ENVELOPE: begin
              st_nxt.dac_on        = |item.write_data[7:3];
              st_nxt.envelope_byte = item.write_data;
              st_nxt.env_timer     = {1'b0, item.write_data[2:0]};
              st_nxt.volume_level  = item.write_data[7:4];
              st_nxt.out_level     = level_calc(st_r.active, |item.write_data[7:3],
                                                item.write_data[7:4], st_r.duty_pos);
            end
            REG_FREQ_LOW: begin
              st_nxt.freq_low_byte = item.write_data;
            end
            REG_FREQ_CTRL: begin
              st_nxt.freq_ctrl_byte = item.write_data;
              if (item.write_data[7]) begin
                st_nxt.period_timer = timer_reload(trig_freq);
                st_nxt.length_count = LENGTH_FULL - {1'b0, st_r.duty_length_byte[5:0]};
                st_nxt.volume_level = st_r.envelope_byte[7:4];
                st_nxt.env_timer    = {1'b0, env_period};
                st_nxt.sweep_active = (sw_period != 3'd0) || (sw_shift != 3'd0);
                st_nxt.sweep_timer  = sw_reload;
                st_nxt.shadow_freq  = trig_freq;
                st_nxt.active       = trig_active;
                st_nxt.out_level    = level_calc(trig_active, st_r.dac_on,
                                                 st_r.envelope_byte[7:4],
                                                 st_r.duty_pos);
              end
            end
            default: begin
            end
          endcase
        end
        MODE_DISABLE: begin
          st_nxt.length_count = 7'd0;
          st_nxt.active       = 1'b0;
          st_nxt.out_level    = 4'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign result.sample_level = st_nxt.out_level;
  assign result.channel_on   = st_nxt.active;

endmodule

`default_nettype wire

// ----- hdl/square_wave_sweep_channel.sv -----
// Square-wave sound channel with frequency sweep, volume envelope and length
// counter. Every input beat is one command (tick, length/sweep/envelope clock,
// register write, disable) and yields exactly one result beat with the held
// sample level and the enable flag. One command is taken per clock unless the
// result side stalls. A beat passes an input register, the combinational state
// update in swc_core and the result register, in that order.
// The input register lets one more command in while a result is stalled.
// Depends on swc_pkg and swc_core.
`default_nettype none

module square_wave_sweep_channel (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire swc_pkg::swc_in_t  in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      swc_pkg::swc_out_t out_data
);
  import swc_pkg::*;

  logic     in_vld_r, in_vld_nxt;
  swc_in_t  in_item_r;
  logic     out_vld_r, out_vld_nxt;
  swc_out_t out_item_r;
  swc_out_t step_result;
  logic     advance;
  logic     in_take;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  swc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .result  (step_result)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// ----- sim/swc_channel_checker.sv -----
// Checker for the square-wave sweep channel: watches both beat channels,
// predicts each result from its own copy of the channel state and compares.
// Depends on swc_pkg for the beat payload types and command codes.
module swc_channel_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  swc_pkg::swc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  swc_pkg::swc_out_t out_data,
  output int                fail_count,
  output int                pending_cnt
);
  import swc_pkg::*;

  localparam int FREQ_MAX  = 2047;

  // duty patterns, one byte per duty setting, bit n is waveform step n
  localparam logic [31:0] DUTY_WAVES = {8'b0111_1110, 8'b1110_0001,
                                        8'b1000_0001, 8'b1000_0000};

  logic [13:0] tick_cnt;
  logic [2:0]  step_idx;
  logic [4:0]  wave_pos;
  logic [7:0]  sweep_reg, duty_reg, env_reg, flo_reg, fctl_reg;
  logic        dac_en;
  logic [3:0]  env_cnt, vol;
  logic [6:0]  len_cnt;
  logic        ch_on;
  logic [3:0]  level;
  logic [3:0]  sweep_cnt;
  logic        sweep_en;
  logic [10:0] shadow;

  swc_out_t expected_samples[$];
  int       errors = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] channel check: %s", $time, msg);
  endtask

  function automatic void clear_channel();
    tick_cnt = '0; step_idx = '0; wave_pos = '0;
    sweep_reg = '0; duty_reg = '0; env_reg = '0; flo_reg = '0; fctl_reg = '0;
    dac_en = 1'b0; env_cnt = '0; vol = '0; len_cnt = '0; ch_on = 1'b0;
    level = '0; sweep_cnt = '0; sweep_en = 1'b0; shadow = '0;
  endfunction

  function automatic void reload_period();
    int t;
    t = (2048 - int'({fctl_reg[2:0], flo_reg})) * 4;
    tick_cnt = t[13:0];
  endfunction

  function automatic void refresh_pos();
    wave_pos = {duty_reg[7:6], step_idx};
  endfunction

  function automatic void refresh_level();
    level = (ch_on && dac_en) ? vol : 4'd0;
    if (!DUTY_WAVES[wave_pos])
      level = 4'd0;
  endfunction

  // next swept frequency from the shadow copy; overflow kills the channel
  function automatic int sweep_probe();
    int base;
    int delta;
    int nf;
    base  = int'(shadow);
    delta = int'(shadow >> sweep_reg[2:0]);
    nf = sweep_reg[3] ? base - delta : base + delta;
    if (nf > FREQ_MAX) begin
      ch_on = 1'b0;
      level = 4'd0;
    end
    return nf;
  endfunction

  function automatic void retrigger();
    reload_period();
    ch_on = 1'b1;
    len_cnt = LENGTH_FULL - {1'b0, duty_reg[5:0]};
    vol = env_reg[7:4];
    env_cnt = {1'b0, env_reg[2:0]};
    sweep_en = (sweep_reg[6:4] != 3'd0) || (sweep_reg[2:0] != 3'd0);
    sweep_cnt = (sweep_reg[6:4] != 3'd0) ? {1'b0, sweep_reg[6:4]} : TIMER_DEFAULT;
    shadow = {fctl_reg[2:0], flo_reg};
    if (sweep_reg[2:0] != 3'd0)
      void'(sweep_probe());
    refresh_level();
  endfunction

  function automatic void sweep_clock();
    int nf;
    if (sweep_cnt > 4'd1) begin
      sweep_cnt = sweep_cnt - 4'd1;
      return;
    end
    sweep_cnt = (sweep_reg[6:4] != 3'd0) ? {1'b0, sweep_reg[6:4]} : TIMER_DEFAULT;
    if (sweep_en && sweep_reg[6:4] != 3'd0) begin
      nf = sweep_probe();
      if (nf <= FREQ_MAX && sweep_reg[2:0] != 3'd0) begin
        shadow = nf[10:0];
        flo_reg = nf[7:0];
        fctl_reg = {fctl_reg[7:3], nf[10:8]};
        void'(sweep_probe());
      end
      void'(sweep_probe());
    end
  endfunction

  function automatic void envelope_clock();
    logic [2:0] per;
    per = env_reg[2:0];
    if (env_cnt > 4'd1) begin
      env_cnt = env_cnt - 4'd1;
      return;
    end
    env_cnt = (per != 3'd0) ? {1'b0, per} : TIMER_DEFAULT;
    if (per != 3'd0) begin
      if (env_reg[3]) begin
        if (vol < 4'd15)
          vol = vol + 4'd1;
      end else if (vol > 4'd0) begin
        vol = vol - 4'd1;
      end
    end
  endfunction

  function automatic void write_register(input logic [2:0] sel, input logic [7:0] data);
    case (sel)
      REG_SWEEP: sweep_reg = data;
      REG_DUTY_LEN: begin
        duty_reg = data;
        refresh_pos();
        refresh_level();
      end
      REG_ENVELOPE: begin
        dac_en = (data[7:3] != 5'd0);
        env_reg = data;
        env_cnt = {1'b0, data[2:0]};
        vol = data[7:4];
        refresh_level();
      end
      REG_FREQ_LOW: flo_reg = data;
      REG_FREQ_CTRL: begin
        fctl_reg = data;
        if (data[7])
          retrigger();
      end
      default: ;
    endcase
  endfunction

  function automatic swc_out_t step_channel(input swc_in_t cmd);
    swc_out_t res;
    case (cmd.mode)
      MODE_TICK: begin
        if (tick_cnt <= 14'd1) begin
          step_idx = step_idx + 3'd1;
          reload_period();
          refresh_pos();
          refresh_level();
        end else begin
          tick_cnt = tick_cnt - 14'd1;
        end
      end
      MODE_LENGTH: begin
        if (len_cnt != 7'd0 && fctl_reg[6]) begin
          len_cnt = len_cnt - 7'd1;
          if (len_cnt == 7'd0) begin
            ch_on = 1'b0;
            level = 4'd0;
          end
        end
      end
      MODE_SWEEP:    sweep_clock();
      MODE_ENVELOPE: envelope_clock();
      MODE_WRITE:    write_register(cmd.reg_select, cmd.write_data);
      MODE_DISABLE: begin
        len_cnt = 7'd0;
        ch_on = 1'b0;
        level = 4'd0;
      end
      default: ;
    endcase
    res.sample_level = level;
    res.channel_on   = ch_on;
    return res;
  endfunction

  initial clear_channel();

  always @(posedge clk) begin
    swc_out_t want;
    if (!rst_n) begin
      clear_channel();
      expected_samples.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_samples.push_back(step_channel(in_data));
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result beat level=%0d on=%0b with nothing expected",
                                    out_data.sample_level, out_data.channel_on));
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample_level !== want.sample_level)
            report_mismatch($sformatf("sample_level got %0d want %0d",
                                      out_data.sample_level, want.sample_level));
          if (out_data.channel_on !== want.channel_on)
            report_mismatch($sformatf("channel_on got %0b want %0b",
                                      out_data.channel_on, want.channel_on));
        end
      end
    end
    pending_cnt <= expected_samples.size();
    fail_count  <= errors;
  end

endmodule

// ----- sim/tb_square_wave_sweep_channel.sv -----
// Testbench top for square_wave_sweep_channel: clock, reset, command beats
// and result-side stalls; swc_channel_checker does the predicting.
// Depends on swc_pkg, square_wave_sweep_channel and swc_channel_checker.
module tb_square_wave_sweep_channel;
  import swc_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // codes the block does not decode
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [2:0] REG_SPARE_A  = 3'd5;
  localparam logic [2:0] REG_SPARE_B  = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  swc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  swc_out_t out_data;
  int       fail_count;
  int       pending_cnt;

  int send_idle_pct = 16;
  int recv_idle_pct = 51;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int counted = 0;

  square_wave_sweep_channel dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  swc_channel_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending_cnt(pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic swc_in_t cmd(input logic [2:0] mode, input logic [2:0] sel,
                                  input logic [7:0] data);
    return {mode, sel, data};
  endfunction

  task automatic send_cmd(input swc_in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (!(c.mode > MODE_DISABLE || (c.mode == MODE_WRITE && c.reg_select > REG_FREQ_CTRL)))
      counted++;
  endtask

  // register write with content biased toward short periods and live output
  function automatic swc_in_t rand_write(input logic [2:0] sel, input int trig_pct);
    int unsigned r;
    logic [7:0] data;
    r = $urandom_range(255);
    data = r[7:0];
    case (sel)
      REG_SWEEP: begin
        if ($urandom_range(99) < 30)
          data = 8'h00;
        else if ($urandom_range(99) < 60)
          data[6] = 1'b0;
      end
      REG_DUTY_LEN: if ($urandom_range(99) < 40) data[5:3] = 3'b111;
      REG_ENVELOPE: begin
        if (data[7:4] == 4'd0 && $urandom_range(99) < 80)
          data[7] = 1'b1;
        if ($urandom_range(99) < 50)
          data[2] = 1'b0;
      end
      REG_FREQ_LOW: begin
        if ($urandom_range(99) < 70) begin
          r = $urandom_range(255, 224);
          data = r[7:0];
        end
      end
      REG_FREQ_CTRL: begin
        if ($urandom_range(99) < 70)
          data[2:0] = 3'b111;
        data[7] = ($urandom_range(99) < trig_pct);
      end
      default: ;
    endcase
    return cmd(MODE_WRITE, sel, data);
  endfunction

  function automatic swc_in_t rand_step();
    int unsigned r;
    int unsigned s;
    int unsigned d;
    r = $urandom_range(99);
    s = $urandom_range(7);
    d = $urandom_range(255);
    if (r < 55) return cmd(MODE_TICK, s[2:0], d[7:0]);
    if (r < 66) return cmd(MODE_LENGTH, s[2:0], d[7:0]);
    if (r < 76) return cmd(MODE_SWEEP, s[2:0], d[7:0]);
    if (r < 86) return cmd(MODE_ENVELOPE, s[2:0], d[7:0]);
    if (r < 95) begin
      s = $urandom_range(4);
      return rand_write(s[2:0], 30);
    end
    if (r < 98) return cmd(MODE_DISABLE, s[2:0], d[7:0]);
    return cmd((d[0] ? MODE_SPARE_A : MODE_SPARE_B), s[2:0], d[7:0]);
  endfunction

  initial begin
    int phase;
    int cur_phase;
    int unsigned n;
    int unsigned m;
    int unsigned s;
    int unsigned d;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle timer, undecoded codes, trigger, sweep overflow, slow timer,
    // DAC off, length expiry, disable
    send_cmd(cmd(MODE_TICK, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_SPARE_A, REG_FREQ_CTRL, 8'hFF));
    send_cmd(cmd(MODE_SPARE_B, REG_SPARE_B, 8'h80));
    send_cmd(cmd(MODE_WRITE, REG_SPARE_A, 8'hFF));
    send_cmd(cmd(MODE_WRITE, REG_SPARE_B, 8'hFF));
    send_cmd(cmd(MODE_WRITE, REG_ENVELOPE, 8'hF0));
    send_cmd(cmd(MODE_WRITE, REG_DUTY_LEN, 8'hC0));
    send_cmd(cmd(MODE_WRITE, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_WRITE, REG_FREQ_LOW, 8'hFF));
    send_cmd(cmd(MODE_WRITE, REG_FREQ_CTRL, 8'hC7));
    repeat (4) send_cmd(cmd(MODE_TICK, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_ENVELOPE, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_SWEEP, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_LENGTH, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_WRITE, REG_SWEEP, 8'h11));
    send_cmd(cmd(MODE_WRITE, REG_FREQ_CTRL, 8'h87));
    send_cmd(cmd(MODE_WRITE, REG_SWEEP, 8'h79));
    send_cmd(cmd(MODE_WRITE, REG_FREQ_LOW, 8'h00));
    send_cmd(cmd(MODE_WRITE, REG_FREQ_CTRL, 8'h80));
    send_cmd(cmd(MODE_WRITE, REG_ENVELOPE, 8'h07));
    send_cmd(cmd(MODE_ENVELOPE, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_WRITE, REG_DUTY_LEN, 8'h3F));
    send_cmd(cmd(MODE_WRITE, REG_FREQ_CTRL, 8'hC0));
    send_cmd(cmd(MODE_LENGTH, REG_SWEEP, 8'h00));
    send_cmd(cmd(MODE_DISABLE, REG_SWEEP, 8'h00));

    counted = 0;
    cur_phase = 0;
    holds_asked <= holds_asked + 1;
    while (counted < RANDOM_ITEMS) begin
      phase = counted * 3 / RANDOM_ITEMS;
      if (phase != cur_phase) begin
        cur_phase = phase;
        if (phase == 1) begin
          send_idle_pct = 51;
          recv_idle_pct <= 16;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          holds_asked <= holds_asked + 1;
        end
      end
      if ($urandom_range(99) < 85) begin
        // program every register, trigger in most cases, then a run of random commands
        send_cmd(rand_write(REG_SWEEP, 0));
        send_cmd(rand_write(REG_DUTY_LEN, 0));
        send_cmd(rand_write(REG_ENVELOPE, 0));
        send_cmd(rand_write(REG_FREQ_LOW, 0));
        send_cmd(rand_write(REG_FREQ_CTRL, 90));
        n = $urandom_range(40, 10);
        repeat (n) send_cmd(rand_step());
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          m = $urandom_range(7);
          s = $urandom_range(7);
          d = $urandom_range(255);
          send_cmd(cmd(m[2:0], s[2:0], d[7:0]));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
